@@ hw/rtl/tcw_pkg.sv @@
// Package with the types and constants of the text console tile writer.
package tcw_pkg;

  localparam int unsigned CoordW = 7;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChBs    = 8'h08;
  localparam logic [7:0] ChBel   = 8'h07;

  typedef enum logic [3:0] {
    CfgWindowLeft  = 4'd0,
    CfgWindowTop   = 4'd1,
    CfgWindowCols  = 4'd2,
    CfgWindowRows  = 4'd3,
    CfgTabWidth    = 4'd4,
    CfgPaletteBits = 4'd5,
    CfgGlyphOffset = 4'd6,
    CfgGlyphCount  = 4'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    RetRead,
    RetWrite,
    RetScroll
  } norm_ret_e;

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StDispatch,
    StNorm,
    StRead,
    StReadDone,
    StCharWr,
    StTab,
    StNewRow,
    StScRow,
    StScRd,
    StScWr,
    StScFill,
    StDone
  } state_e;

  typedef struct packed {
    logic [3:0]  index;
    logic [15:0] data;
  } cfg_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_code;
    logic [4:0] read_col;
    logic [4:0] read_row;
  } req_t;

  typedef struct packed {
    logic [5:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [15:0] cell_value;
    logic        dropped;
  } rsp_t;

endpackage

@@ hw/rtl/tcw_stream_if.sv @@
// Valid/ready channel interface carrying one payload type.
interface tcw_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/text_console_tile_writer_core.sv @@
// Text console tile writer: tile map, cursor, window scroll and cell reads.
// After reset the tile map is cleared one entry a cycle while no item is
// accepted. One item is worked at a time and a result is given for each. A
// read reduces its address by wrap steps and then reads the cell; an ordinary
// character does the same wrap steps and then writes the cell; tab steps
// through the tab stops one at a time; a scroll walks the window through the
// memory, a read and a write per copied cell and a write per filled cell.
// All coordinate reduction goes through the one StNorm state.
module text_console_tile_writer_core #(
  parameter int unsigned MAP_PITCH = 32,
  parameter int unsigned MAP_ROWS  = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tcw_stream_if.sink   cfg_i,
  tcw_stream_if.sink   req_i,
  tcw_stream_if.source rsp_o
);
  import tcw_pkg::*;

  localparam int unsigned MapSize = MAP_PITCH * MAP_ROWS;
  localparam int unsigned AddrW   = $clog2(MapSize);
  localparam logic [CoordW-1:0] Pitch = CoordW'(MAP_PITCH);
  localparam logic [CoordW-1:0] Rows  = CoordW'(MAP_ROWS);

  logic [15:0] mem_q [MapSize];
  logic [15:0] rdata_q;

  state_e state_q, state_d;
  norm_ret_e ret_q, ret_d;

  logic [4:0]  left_q, top_q;
  logic [5:0]  cols_q, rows_q, tabw_q;
  logic [15:0] pal_q;
  logic [10:0] goff_q, gcnt_q;

  logic [5:0] cx_q, cx_d;
  logic [4:0] cy_q, cy_d;
  logic [7:0] ch_q, ch_d;
  logic wrap_q, wrap_d, nl_q, nl_d, drop_q, drop_d;
  logic [15:0] cell_q, cell_d;
  logic [CoordW-1:0] nc_q, nc_d, nr_q, nr_d;
  logic [CoordW-1:0] c0_q, c0_d, rr_q, rr_d;
  logic [CoordW-1:0] dc_q, dc_d, dr_q, dr_d, sc_q, sc_d, sr_q, sr_d;
  logic [4:0] r_q, r_d;
  logic [5:0] k_q, k_d;
  logic [CoordW-1:0] acc_q, acc_d;
  logic [AddrW-1:0] clr_q;

  logic out_valid_q;
  rsp_t out_q;

  logic [5:0] rows_eff, tw_eff;
  logic signed [11:0] glyph_in, glyph_sp, glyph_ch;
  logic [15:0] entry_sp, entry_ch;
  logic in_drop, out_free, last_cell, copy_row, nr_scroll;

  logic mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [15:0] mem_wdata;

  function automatic logic [AddrW-1:0] addr_of(logic [CoordW-1:0] c, logic [CoordW-1:0] r);
    return AddrW'(r) * AddrW'(MAP_PITCH) + AddrW'(c);
  endfunction

  function automatic logic [CoordW-1:0] row_inc(logic [CoordW-1:0] r);
    return (r + 1'b1 == Rows) ? '0 : r + 1'b1;
  endfunction

  always_comb begin
    rows_eff = (rows_q == 6'd0) ? 6'd1 : ((rows_q > 6'd32) ? 6'd32 : rows_q);
    tw_eff   = (tabw_q == 6'd0) ? 6'd1 : tabw_q;
    glyph_in = $signed({4'b0, req_i.data.char_code}) + $signed({goff_q[10], goff_q});
    glyph_sp = $signed({4'b0, ChSpace}) + $signed({goff_q[10], goff_q});
    glyph_ch = $signed({4'b0, ch_q}) + $signed({goff_q[10], goff_q});
    entry_sp = pal_q | {{4{glyph_sp[11]}}, glyph_sp};
    entry_ch = pal_q | {{4{glyph_ch[11]}}, glyph_ch};
    in_drop  = (req_i.data.char_code == 8'd0) ||
               ($signed({glyph_in[11], glyph_in}) > $signed({2'b00, gcnt_q}));
    out_free  = !out_valid_q || rsp_o.ready;
    last_cell = (k_q + 6'd1 == cols_q);
    copy_row  = ({1'b0, r_q} + 6'd1 < rows_eff);
    nr_scroll = ({1'b0, cy_q} + 6'd1 >= rows_eff);
  end

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == StIdle);
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear:    if (clr_q == AddrW'(MapSize - 1)) state_d = StIdle;
      StIdle: begin
        if (req_i.valid) begin
          if (req_i.data.req_type) state_d = StNorm;
          else if (in_drop)        state_d = StDone;
          else                     state_d = StDispatch;
        end
      end
      StDispatch: begin
        if (wrap_q) state_d = StNewRow;
        else begin
          case (ch_q)
            ChBel, ChBs, ChCr: state_d = StDone;
            ChTab:             state_d = StTab;
            ChNl:              state_d = nl_q ? StDone : StNewRow;
            default:           state_d = StNorm;
          endcase
        end
      end
      StNorm: begin
        if (nc_q < Pitch && nr_q < Rows) begin
          case (ret_q)
            RetRead:   state_d = StRead;
            RetWrite:  state_d = StCharWr;
            RetScroll: state_d = StScRow;
            default:   state_d = StIdle;
          endcase
        end
      end
      StRead:     state_d = StReadDone;
      StReadDone: state_d = StDone;
      StCharWr:   state_d = StDone;
      StTab:      if (acc_q > {1'b0, cx_q}) state_d = StDone;
      StNewRow:   state_d = nr_scroll ? StNorm : StDispatch;
      StScRow: begin
        if (cols_q == 6'd0) state_d = StDispatch;
        else                state_d = copy_row ? StScRd : StScFill;
      end
      StScRd:     state_d = StScWr;
      StScWr:     state_d = last_cell ? StScRow : StScRd;
      StScFill:   if (last_cell) state_d = StDispatch;
      StDone:     if (out_free) state_d = StIdle;
      default:    state_d = StIdle;
    endcase
  end

  always_comb begin
    cx_d = cx_q; cy_d = cy_q; ch_d = ch_q; wrap_d = wrap_q; nl_d = nl_q;
    drop_d = drop_q; cell_d = cell_q; nc_d = nc_q; nr_d = nr_q; ret_d = ret_q;
    c0_d = c0_q; rr_d = rr_q; dc_d = dc_q; dr_d = dr_q; sc_d = sc_q; sr_d = sr_q;
    r_d = r_q; k_d = k_q; acc_d = acc_q;
    mem_we = 1'b0; mem_waddr = clr_q; mem_wdata = '0;
    mem_raddr = addr_of(sc_q, sr_q);
    case (state_q)
      StClear:    mem_we = 1'b1;
      StIdle: begin
        ch_d   = req_i.data.char_code;
        cell_d = '0;
        drop_d = 1'b0;
        nl_d   = 1'b0;
        wrap_d = (cx_q >= cols_q);
        nc_d   = CoordW'(req_i.data.read_col);
        nr_d   = CoordW'(req_i.data.read_row);
        ret_d  = RetRead;
        if (!req_i.data.req_type && in_drop) drop_d = 1'b1;
      end
      StDispatch: begin
        if (wrap_q) begin
          wrap_d = 1'b0;
          cx_d   = '0;
        end else begin
          case (ch_q)
            ChBel, ChBs: ;
            ChCr:  cx_d = '0;
            ChTab: acc_d = '0;
            ChNl: begin
              if (nl_q) cx_d = '0;
              else      nl_d = 1'b1;
            end
            default: begin
              nc_d  = CoordW'(cx_q) + CoordW'(left_q);
              nr_d  = CoordW'(cy_q) + CoordW'(top_q);
              ret_d = RetWrite;
            end
          endcase
        end
      end
      StNorm: begin
        if (nc_q >= Pitch) begin
          nc_d = nc_q - Pitch;
          nr_d = nr_q + 1'b1;
        end else if (nr_q >= Rows) begin
          nr_d = nr_q - Rows;
        end else begin
          c0_d = nc_q;
          rr_d = nr_q;
          r_d  = '0;
        end
      end
      StRead:     mem_raddr = addr_of(nc_q, nr_q);
      StReadDone: cell_d = rdata_q;
      StCharWr: begin
        mem_we    = 1'b1;
        mem_waddr = addr_of(nc_q, nr_q);
        mem_wdata = entry_ch;
        cx_d      = (cx_q == 6'd63) ? cx_q : cx_q + 6'd1;
      end
      StTab: begin
        if (acc_q <= {1'b0, cx_q}) acc_d = acc_q + CoordW'(tw_eff);
        else cx_d = (acc_q > CoordW'(63)) ? 6'd63 : acc_q[5:0];
      end
      StNewRow: begin
        if (nr_scroll) begin
          nc_d  = CoordW'(left_q);
          nr_d  = CoordW'(top_q);
          ret_d = RetScroll;
        end else begin
          cy_d = cy_q + 5'd1;
        end
      end
      StScRow: begin
        dc_d = c0_q;
        dr_d = rr_q;
        sc_d = c0_q;
        sr_d = row_inc(rr_q);
        k_d  = '0;
      end
      StScWr: begin
        mem_we    = 1'b1;
        mem_waddr = addr_of(dc_q, dr_q);
        mem_wdata = rdata_q;
        k_d       = k_q + 6'd1;
        if (dc_q + 1'b1 == Pitch) begin
          dc_d = '0;
          dr_d = row_inc(dr_q);
        end else dc_d = dc_q + 1'b1;
        if (sc_q + 1'b1 == Pitch) begin
          sc_d = '0;
          sr_d = row_inc(sr_q);
        end else sc_d = sc_q + 1'b1;
        if (last_cell) begin
          rr_d = row_inc(rr_q);
          r_d  = r_q + 5'd1;
        end
      end
      StScFill: begin
        mem_we    = 1'b1;
        mem_waddr = addr_of(dc_q, dr_q);
        mem_wdata = entry_sp;
        k_d       = k_q + 6'd1;
        if (dc_q + 1'b1 == Pitch) begin
          dc_d = '0;
          dr_d = row_inc(dr_q);
        end else dc_d = dc_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rdata_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      left_q  <= 5'd0;
      top_q   <= 5'd0;
      cols_q  <= 6'd32;
      rows_q  <= 6'd24;
      tabw_q  <= 6'd3;
      pal_q   <= 16'd0;
      goff_q  <= 11'h7E0;
      gcnt_q  <= 11'd96;
      cx_q    <= '0;
      cy_q    <= '0;
      wrap_q  <= 1'b0;
      nl_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StClear) clr_q <= clr_q + 1'b1;
      if (cfg_i.valid) begin
        case (cfg_i.data.index)
          CfgWindowLeft:  left_q <= cfg_i.data.data[4:0];
          CfgWindowTop:   top_q  <= cfg_i.data.data[4:0];
          CfgWindowCols:  cols_q <= cfg_i.data.data[5:0];
          CfgWindowRows:  rows_q <= cfg_i.data.data[5:0];
          CfgTabWidth:    tabw_q <= cfg_i.data.data[5:0];
          CfgPaletteBits: pal_q  <= cfg_i.data.data;
          CfgGlyphOffset: goff_q <= cfg_i.data.data[10:0];
          CfgGlyphCount:  gcnt_q <= cfg_i.data.data[10:0];
          default: ;
        endcase
      end
      cx_q   <= cx_d;
      cy_q   <= cy_d;
      wrap_q <= wrap_d;
      nl_q   <= nl_d;
      if (state_q == StDone && out_free) out_valid_q <= 1'b1;
      else if (rsp_o.ready)              out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q <= ch_d; drop_q <= drop_d; cell_q <= cell_d; ret_q <= ret_d;
    nc_q <= nc_d; nr_q <= nr_d; c0_q <= c0_d; rr_q <= rr_d;
    dc_q <= dc_d; dr_q <= dr_d; sc_q <= sc_d; sr_q <= sr_d;
    r_q <= r_d; k_q <= k_d; acc_q <= acc_d;
    if (state_q == StDone && out_free) begin
      out_q.cursor_col <= cx_q;
      out_q.cursor_row <= cy_q;
      out_q.cell_value <= cell_q;
      out_q.dropped    <= drop_q;
    end
  end

endmodule

@@ hw/rtl/tcw_checker.sv @@
// Port-level checker for the text console tile writer, bound to the top level.
module tcw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input tcw_pkg::rsp_t out_data_i
);
  import tcw_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken on consecutive cycles");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.dropped |-> out_data_i.cell_value == 16'd0)
    else $error("dropped print carries a cell value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !in_ready_i || !$past(in_ready_i))
    else $error("result without work");

endmodule

bind text_console_tile_writer_core tcw_checker u_tcw_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (req_i.valid),
  .in_ready_i (req_i.ready),
  .out_valid_i(rsp_o.valid),
  .out_ready_i(rsp_o.ready),
  .out_data_i (rsp_o.data)
);
